// ===== rtl/core/opmt_pkg.sv =====
// Package for the option header message type parser.
// Holds payload structs, parse phase enum, parser state struct, sizing constants, reset value and status codes.
// No dependencies.
package opmt_pkg;

    // Default and upper bound of option fields in a header
    localparam int OPT_FIELD_COUNT_DEF = 6;
    localparam int OPT_FIELD_MAX       = 7;
    localparam int OPT_IDX_W           = 3;

    // Reset value of the header flag mask register
    localparam logic [7:0] HEADER_FLAG_MASK_RST = 8'h80;

    // Result status codes
    localparam logic STATUS_FOUND     = 1'b0;
    localparam logic STATUS_TRUNCATED = 1'b1;

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_OPT_LEN,
        PH_SKIP,
        PH_SERVICE,
        PH_TYPE,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [7:0] message_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] message_type;
        logic       status;
    } t_out_item;

    typedef struct packed {
        t_phase                     phase;
        logic [OPT_FIELD_MAX-1:0]   options_present;
        logic [OPT_IDX_W-1:0]       option_index;
        logic [7:0]                 bytes_to_skip;
    } t_parse_state;

endpackage

// ===== rtl/core/opmt_step.sv =====
// Per-byte parse step: next parser state and optional result for one byte.
// Purely combinational; depends on opmt_pkg.
module opmt_step
    import opmt_pkg::*;
#(
    parameter int OPTION_FIELD_COUNT = OPT_FIELD_COUNT_DEF
) (
    input  t_parse_state i_state,
    input  t_in_item     i_item,
    input  logic [7:0]   i_flag_mask,
    output t_parse_state o_state,
    output logic         o_res_valid,
    output t_out_item    o_res
);

    localparam logic [OPT_IDX_W-1:0]     IDX_END  = OPT_IDX_W'(OPTION_FIELD_COUNT);
    localparam logic [OPT_FIELD_MAX-1:0] OPT_BITS =
        OPT_FIELD_MAX'((1 << OPTION_FIELD_COUNT) - 1);

    logic [OPT_FIELD_MAX-1:0] seek_present;
    logic [OPT_IDX_W-1:0]     seek_start;
    logic [OPT_IDX_W-1:0]     seek_idx;
    t_phase                   seek_phase;
    logic [7:0]               skip_dec;

    // Pick the option set and start index for the next-option search
    always_comb begin
        if (i_state.phase == PH_FIRST) begin
            seek_present = i_item.message_byte[OPT_FIELD_MAX-1:0] & OPT_BITS;
            seek_start   = '0;
        end else begin
            seek_present = i_state.options_present;
            seek_start   = i_state.option_index + OPT_IDX_W'(1);
        end
    end

    // Find the lowest present option at or after the start index
    always_comb begin
        seek_idx = IDX_END;
        for (int i = OPTION_FIELD_COUNT - 1; i >= 0; i--) begin
            if (OPT_IDX_W'(i) >= seek_start && seek_present[i]) begin
                seek_idx = OPT_IDX_W'(i);
            end
        end
        seek_phase = (seek_idx < IDX_END) ? PH_OPT_LEN : PH_SERVICE;
    end

    assign skip_dec = i_state.bytes_to_skip - 8'd1;

    // Advance the parser by one byte
    always_comb begin
        o_state     = i_state;
        o_res_valid = 1'b0;
        o_res       = '0;
        case (i_state.phase)
            PH_FIRST: begin
                if ((i_item.message_byte & i_flag_mask) != 8'd0) begin
                    o_state.options_present = seek_present;
                    o_state.option_index    = seek_idx;
                    o_state.phase           = seek_phase;
                end else begin
                    o_state.phase = PH_TYPE;
                end
            end
            PH_OPT_LEN: begin
                o_state.bytes_to_skip = i_item.message_byte;
                if (i_item.message_byte == 8'd0) begin
                    o_state.option_index = seek_idx;
                    o_state.phase        = seek_phase;
                end else begin
                    o_state.phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                o_state.bytes_to_skip = skip_dec;
                if (skip_dec == 8'd0) begin
                    o_state.option_index = seek_idx;
                    o_state.phase        = seek_phase;
                end
            end
            PH_SERVICE: begin
                o_state.phase = PH_TYPE;
            end
            PH_TYPE: begin
                o_res_valid        = 1'b1;
                o_res.message_type = i_item.message_byte;
                o_res.status       = STATUS_FOUND;
                o_state.phase      = PH_DONE;
            end
            default: begin
            end
        endcase

        // End of message: report truncation if no type yet, then restart
        if (i_item.last_byte) begin
            if (i_state.phase != PH_DONE && !o_res_valid) begin
                o_res_valid        = 1'b1;
                o_res.message_type = 8'd0;
                o_res.status       = STATUS_TRUNCATED;
            end
            o_state.phase           = PH_FIRST;
            o_state.options_present = '0;
            o_state.option_index    = '0;
            o_state.bytes_to_skip   = 8'd0;
        end
    end

endmodule

// ===== rtl/core/opmt_out_reg.sv =====
// Result register: holds one result until the downstream side takes it.
// Depends on opmt_pkg.
module opmt_out_reg
    import opmt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_item i_data,
    output logic      o_free,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    logic      r_valid;
    logic      n_valid;
    t_out_item r_data;

    // Free when empty or when the held result transfers this cycle
    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (o_free) begin
            n_valid = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Capture payload on load
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== rtl/core/option_header_message_type_parser_unit.sv =====
// A byte is registered on transfer, then parsed from the input register into the result
// register once that register is free; the result is offered from the result register.
// Throughput: one byte per cycle; the input register advances whenever the result
// register is empty or its result transfers in the same cycle.
// Reset (synchronous, active low): parser returns to the first byte phase, both
// registers empty, header flag mask 0x80.
module option_header_message_type_parser_unit
    import opmt_pkg::*;
#(
    parameter int OPTION_FIELD_COUNT = OPT_FIELD_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_data,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_item  o_out_data,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    logic         r_in_valid;
    logic         n_in_valid;
    t_in_item     r_in;
    logic [7:0]   r_flag_mask;
    t_parse_state r_state;
    t_parse_state n_state;
    t_parse_state step_state;
    logic         step_res_valid;
    t_out_item    step_res;
    logic         out_free;
    logic         advance;

    // Configuration write: always accepted
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag_mask <= HEADER_FLAG_MASK_RST;
        end else if (i_cfg_valid) begin
            r_flag_mask <= i_cfg_data;
        end
    end

    // Parse the held byte when the result register can take its outcome
    assign advance    = r_in_valid && out_free;
    assign o_in_ready = !r_in_valid || advance;

    always_comb begin
        n_in_valid = r_in_valid;
        if (o_in_ready) begin
            n_in_valid = i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // Capture input payload on transfer
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    opmt_step #(
        .OPTION_FIELD_COUNT(OPTION_FIELD_COUNT)
    ) u_step (
        .i_state     (r_state),
        .i_item      (r_in),
        .i_flag_mask (r_flag_mask),
        .o_state     (step_state),
        .o_res_valid (step_res_valid),
        .o_res       (step_res)
    );

    // Hold parser state unless a byte is consumed
    always_comb begin
        n_state = r_state;
        if (advance) begin
            n_state = step_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase           <= PH_FIRST;
            r_state.options_present <= '0;
            r_state.option_index    <= '0;
            r_state.bytes_to_skip   <= 8'd0;
        end else begin
            r_state <= n_state;
        end
    end

    opmt_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && step_res_valid),
        .i_data  (step_res),
        .o_free  (out_free),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

`ifndef SYNTHESIS
    // A consumed last byte always restarts the parser
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.last_byte |=> r_state.phase == PH_FIRST)
        else $error("parser did not restart after last byte");

    // Truncation results carry a zero type
    a_trunc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == STATUS_TRUNCATED |->
            o_out_data.message_type == 8'd0)
        else $error("truncation result with nonzero type");

    // Skip phase always has bytes left to skip
    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_SKIP |-> r_state.bytes_to_skip != 8'd0)
        else $error("skip phase with zero count");

    // Option index stays inside the field range while reading a length
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_OPT_LEN |->
            r_state.option_index < OPT_IDX_W'(OPTION_FIELD_COUNT))
        else $error("option index out of range");
`endif

endmodule
